FILE: hw/rtl/kpp_pkg.sv
`timescale 1ns / 1ps

package kpp_pkg;

    localparam int MAX_FRAMES = 1024;
    localparam int IDX_W      = $clog2(MAX_FRAMES);
    localparam int CNT_W      = IDX_W + 1;
    localparam int POSE_W     = 192;
    localparam logic [15:0] SPEED_RESET = 16'd256;

    localparam logic [2:0] OP_APPEND = 3'd0;
    localparam logic [2:0] OP_CLEAR  = 3'd1;
    localparam logic [2:0] OP_START  = 3'd2;
    localparam logic [2:0] OP_STOP   = 3'd3;
    localparam logic [2:0] OP_SEEK   = 3'd4;
    localparam logic [2:0] OP_TICK   = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE, S_LAST, S_ADV, S_SRCH, S_SCMP, S_PFRM, S_WALK, S_WCMP,
        S_SA, S_DIV, S_PA, S_PB, S_PC, S_MUL, S_ADD, S_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [9:0]        frame_index;
        logic [31:0]       playhead;
        logic              playing;
        logic [POSE_W-1:0] pose;
        logic              pose_valid;
    } result_t;

endpackage

FILE: hw/rtl/kpp_ram.sv
`timescale 1ns / 1ps

module kpp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hw/rtl/kpp_core.sv
`timescale 1ns / 1ps

module kpp_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [2:0]                    in_op,
    input  logic [31:0]                   in_tv,
    input  logic [kpp_pkg::POSE_W-1:0]    in_pose,
    input  logic [15:0]                   speed,
    output logic                          res_valid,
    input  logic                          res_ready,
    output kpp_pkg::result_t              result
);

    localparam int IW = kpp_pkg::IDX_W;
    localparam int CW = kpp_pkg::CNT_W;

    kpp_pkg::state_t state_reg, state_next;

    logic [2:0]                 op_reg;
    logic [31:0]                tv_reg;
    logic [CW-1:0]              cnt_reg;
    logic [IW-1:0]              idx_reg;
    logic [31:0]                time_reg;
    logic                       play_reg;
    logic [1:0]                 status_reg;
    logic [31:0]                last_reg;
    logic [IW-1:0]              lo_reg, hi_reg;
    logic [31:0]                sb_reg, d_reg, r_reg;
    logic [15:0]                q_reg, alpha_reg;
    logic [3:0]                 dcnt_reg;
    logic [kpp_pkg::POSE_W-1:0] pa_reg, pb_reg, res_reg;
    logic [2:0]                 comp_reg;
    logic                       pv_reg;
    logic signed [49:0]         prod_reg;

    logic                       stamp_re, pose_re;
    logic [IW-1:0]              stamp_raddr, pose_raddr;
    logic [31:0]                stamp_rdata;
    logic [kpp_pkg::POSE_W-1:0] pose_rdata;
    logic                       wr_en;

    logic                       accept;
    logic [CW-1:0]              cnt_m1, idx_p1, mid_sum;
    logic [IW-1:0]              mid;
    logic [40:0]                sum;
    logic [31:0]                tsat;
    logic                       blend_ok, alpha_full;
    logic [31:0]                diff, dd;
    logic [32:0]                r2;
    logic                       ge;
    logic signed [32:0]         mul_a, comp_a, comp_b;
    logic signed [16:0]         mul_b;

    assign accept   = in_valid && in_ready;
    assign cnt_m1   = cnt_reg - CW'(1);
    assign idx_p1   = {1'b0, idx_reg} + CW'(1);
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid      = mid_sum[CW-1:1];
    assign sum      = {9'b0, time_reg} + {1'b0, prod_reg[47:8]};
    assign tsat     = (sum[40:32] != 9'b0) ? 32'hFFFF_FFFF : sum[31:0];
    assign diff     = time_reg - stamp_rdata;
    assign dd       = sb_reg - stamp_rdata;
    assign blend_ok = (sb_reg > stamp_rdata) && (time_reg > stamp_rdata);
    assign alpha_full = diff >= dd;
    assign r2       = {r_reg, 1'b0};
    assign ge       = r2 >= {1'b0, d_reg};
    assign wr_en    = accept && (in_op == kpp_pkg::OP_APPEND)
                      && (cnt_reg < CW'(kpp_pkg::MAX_FRAMES));

    assign comp_a = {pa_reg[comp_reg*32+31], pa_reg[comp_reg*32 +: 32]};
    assign comp_b = {pb_reg[comp_reg*32+31], pb_reg[comp_reg*32 +: 32]};

    // shared multiplier: tick advance and lerp products
    always_comb begin
        if (state_reg == kpp_pkg::S_LAST) begin
            mul_a = {1'b0, tv_reg};
            mul_b = {1'b0, speed};
        end else begin
            mul_a = comp_b - comp_a;
            mul_b = {1'b0, alpha_reg};
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    kpp_ram #(.WIDTH(32), .DEPTH(kpp_pkg::MAX_FRAMES)) u_stamp_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (cnt_reg[IW-1:0]),
        .wdata (in_tv),
        .re    (stamp_re),
        .raddr (stamp_raddr),
        .rdata (stamp_rdata)
    );

    kpp_ram #(.WIDTH(kpp_pkg::POSE_W), .DEPTH(kpp_pkg::MAX_FRAMES)) u_pose_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (cnt_reg[IW-1:0]),
        .wdata (in_pose),
        .re    (pose_re),
        .raddr (pose_raddr),
        .rdata (pose_rdata)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            kpp_pkg::S_IDLE: begin
                if (in_valid) begin
                    if (cnt_reg != '0 && (in_op == kpp_pkg::OP_SEEK
                        || (in_op == kpp_pkg::OP_TICK && play_reg))) begin
                        state_next = kpp_pkg::S_LAST;
                    end else begin
                        state_next = kpp_pkg::S_DONE;
                    end
                end
            end
            kpp_pkg::S_LAST: begin
                state_next = (op_reg == kpp_pkg::OP_SEEK) ? kpp_pkg::S_SRCH
                                                          : kpp_pkg::S_ADV;
            end
            kpp_pkg::S_ADV: begin
                state_next = (tsat >= last_reg) ? kpp_pkg::S_DONE : kpp_pkg::S_WALK;
            end
            kpp_pkg::S_SRCH: begin
                state_next = (lo_reg < hi_reg) ? kpp_pkg::S_SCMP : kpp_pkg::S_PFRM;
            end
            kpp_pkg::S_SCMP: state_next = kpp_pkg::S_SRCH;
            kpp_pkg::S_PFRM: state_next = kpp_pkg::S_DONE;
            kpp_pkg::S_WALK: begin
                state_next = (idx_p1 < cnt_reg) ? kpp_pkg::S_WCMP : kpp_pkg::S_PFRM;
            end
            kpp_pkg::S_WCMP: begin
                state_next = (stamp_rdata <= time_reg) ? kpp_pkg::S_WALK
                                                        : kpp_pkg::S_SA;
            end
            kpp_pkg::S_SA: begin
                state_next = (blend_ok && !alpha_full) ? kpp_pkg::S_DIV
                                                       : kpp_pkg::S_PA;
            end
            kpp_pkg::S_DIV: begin
                if (dcnt_reg == 4'd15) begin
                    state_next = kpp_pkg::S_PA;
                end
            end
            kpp_pkg::S_PA:  state_next = kpp_pkg::S_PB;
            kpp_pkg::S_PB:  state_next = kpp_pkg::S_PC;
            kpp_pkg::S_PC:  state_next = kpp_pkg::S_MUL;
            kpp_pkg::S_MUL: state_next = kpp_pkg::S_ADD;
            kpp_pkg::S_ADD: begin
                state_next = (comp_reg == 3'd5) ? kpp_pkg::S_DONE : kpp_pkg::S_MUL;
            end
            kpp_pkg::S_DONE: begin
                if (res_ready) begin
                    state_next = kpp_pkg::S_IDLE;
                end
            end
            default: state_next = kpp_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        in_ready    = 1'b0;
        res_valid   = 1'b0;
        stamp_re    = 1'b0;
        stamp_raddr = idx_reg;
        pose_re     = 1'b0;
        pose_raddr  = idx_reg;
        unique case (state_reg)
            kpp_pkg::S_IDLE: begin
                in_ready    = 1'b1;
                stamp_re    = 1'b1;
                stamp_raddr = cnt_m1[IW-1:0];
            end
            kpp_pkg::S_SRCH: begin
                stamp_re    = 1'b1;
                stamp_raddr = mid;
                pose_re     = 1'b1;
                pose_raddr  = lo_reg;
            end
            kpp_pkg::S_WALK: begin
                stamp_re    = 1'b1;
                stamp_raddr = idx_p1[IW-1:0];
                pose_re     = 1'b1;
            end
            kpp_pkg::S_WCMP: stamp_re = 1'b1;
            kpp_pkg::S_PA:   pose_re = 1'b1;
            kpp_pkg::S_PB: begin
                pose_re    = 1'b1;
                pose_raddr = idx_p1[IW-1:0];
            end
            kpp_pkg::S_DONE: res_valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= kpp_pkg::S_IDLE;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            time_reg  <= '0;
            play_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                kpp_pkg::S_IDLE: begin
                    if (accept) begin
                        op_reg     <= in_op;
                        tv_reg     <= in_tv;
                        status_reg <= kpp_pkg::ST_OK;
                        pv_reg     <= 1'b0;
                        res_reg    <= '0;
                        case (in_op)
                            kpp_pkg::OP_APPEND: begin
                                if (wr_en) begin
                                    cnt_reg <= cnt_reg + CW'(1);
                                end else begin
                                    status_reg <= kpp_pkg::ST_FULL;
                                end
                            end
                            kpp_pkg::OP_CLEAR: begin
                                cnt_reg  <= '0;
                                idx_reg  <= '0;
                                time_reg <= '0;
                                play_reg <= 1'b0;
                            end
                            kpp_pkg::OP_STOP: play_reg <= 1'b0;
                            kpp_pkg::OP_START, kpp_pkg::OP_SEEK, kpp_pkg::OP_TICK: begin
                                if (cnt_reg == '0) begin
                                    status_reg <= kpp_pkg::ST_EMPTY;
                                end else if (in_op == kpp_pkg::OP_START) begin
                                    time_reg <= '0;
                                    idx_reg  <= '0;
                                    play_reg <= 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                kpp_pkg::S_LAST: begin
                    last_reg <= stamp_rdata;
                    if (op_reg == kpp_pkg::OP_SEEK) begin
                        time_reg <= (tv_reg < stamp_rdata) ? tv_reg : stamp_rdata;
                        lo_reg   <= '0;
                        hi_reg   <= cnt_m1[IW-1:0];
                    end
                end
                kpp_pkg::S_ADV: begin
                    if (tsat >= last_reg) begin
                        play_reg <= 1'b0;
                        time_reg <= last_reg;
                    end else begin
                        time_reg <= tsat;
                    end
                end
                kpp_pkg::S_SRCH: begin
                    if (lo_reg >= hi_reg) begin
                        idx_reg <= lo_reg;
                    end
                end
                kpp_pkg::S_SCMP: begin
                    if (stamp_rdata < time_reg) begin
                        lo_reg <= mid + IW'(1);
                    end else begin
                        hi_reg <= mid;
                    end
                end
                kpp_pkg::S_PFRM: begin
                    res_reg <= pose_rdata;
                    pv_reg  <= 1'b1;
                end
                kpp_pkg::S_WCMP: begin
                    if (stamp_rdata <= time_reg) begin
                        idx_reg <= idx_p1[IW-1:0];
                    end else begin
                        sb_reg <= stamp_rdata;
                    end
                end
                kpp_pkg::S_SA: begin
                    r_reg    <= diff;
                    d_reg    <= dd;
                    q_reg    <= '0;
                    dcnt_reg <= '0;
                    if (!blend_ok) begin
                        alpha_reg <= '0;
                    end else if (alpha_full) begin
                        alpha_reg <= 16'hFFFF;
                    end
                end
                kpp_pkg::S_DIV: begin
                    r_reg    <= ge ? 32'(r2 - {1'b0, d_reg}) : r2[31:0];
                    q_reg    <= {q_reg[14:0], ge};
                    dcnt_reg <= dcnt_reg + 4'd1;
                    if (dcnt_reg == 4'd15) begin
                        alpha_reg <= {q_reg[14:0], ge};
                    end
                end
                kpp_pkg::S_PB: pa_reg <= pose_rdata;
                kpp_pkg::S_PC: begin
                    pb_reg   <= pose_rdata;
                    comp_reg <= '0;
                end
                kpp_pkg::S_ADD: begin
                    res_reg[comp_reg*32 +: 32] <= pa_reg[comp_reg*32 +: 32]
                                                  + prod_reg[47:16];
                    comp_reg <= comp_reg + 3'd1;
                    if (comp_reg == 3'd5) begin
                        pv_reg <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign result.status      = status_reg;
    assign result.frame_index = 10'(idx_reg);
    assign result.playhead    = time_reg;
    assign result.playing     = play_reg;
    assign result.pose        = res_reg;
    assign result.pose_valid  = pv_reg;

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(kpp_pkg::MAX_FRAMES))
        else $error("frame count past table size");

    a_walk_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == kpp_pkg::S_WCMP) |-> (idx_p1 < cnt_reg))
        else $error("walk reads beyond filled table");

    a_search_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == kpp_pkg::S_SCMP) |=> (lo_reg <= hi_reg))
        else $error("search bounds crossed");

    a_div_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == kpp_pkg::S_DIV && dcnt_reg != 4'd15)
        |=> (state_reg == kpp_pkg::S_DIV))
        else $error("divider left early");

endmodule

FILE: hw/rtl/keyframe_pose_playback.sv
`timescale 1ns / 1ps
// keyframe pose playback
// input channel s_*: one transfer per command; tuser carries op, tdata the
// stamp/target/delta and the six pose components of an appended frame
// result channel m_*: exactly one transfer per command, in command order
// cfg_wen/cfg_wdata: playback speed, unsigned Q8.8, write only while idle
// append, clear, start, stop, unused codes, empty-table commands and ticks
// while stopped go straight to the result; a seek runs a binary search over
// the stamps (about log2 of the frame count steps); a tick that ends
// playback only advances the playhead; any other tick walks frame by frame,
// runs the divider (16 steps, skipped when no division is needed), reads the
// two bracketing poses and runs six multiply/add rounds
// the sequencer handles one command at a time; one 33x17 multiplier,
// a 16-step restoring divider and single-port reads of the stamp and pose
// tables set the pace of each command
// s_tready is high only while the sequencer is idle; the output register
// frees the sequencer once loaded, so a stalled receiver holds only the
// following result
// reset empties the table, zeroes playhead and index, stops playback and
// sets speed to 256; no clearing pass is needed
module keyframe_pose_playback (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [223:0] s_tdata,  // time_value, pos_x, pos_y, pos_z, rot_pitch, rot_yaw, rot_roll
    input  logic [2:0]   s_tuser,  // op
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [239:0] m_tdata,  // out_x, out_y, out_z, out_pitch, out_yaw, out_roll,
                                   // is_playing, playhead_time, frame_index, status, zero pad
    output logic [0:0]   m_tuser,  // pose_valid
    input  logic         cfg_wen,
    input  logic [15:0]  cfg_wdata
);

    logic [15:0]      speed_reg;
    logic             m_valid_reg;
    kpp_pkg::result_t out_reg;
    kpp_pkg::result_t result;
    logic             res_valid, res_ready;

    assign res_ready = !m_valid_reg || m_tready;

    kpp_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tuser),
        .in_tv     (s_tdata[31:0]),
        .in_pose   (s_tdata[223:32]),
        .speed     (speed_reg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .result    (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_reg   <= kpp_pkg::SPEED_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wen) begin
                speed_reg <= cfg_wdata;
            end
            if (res_ready) begin
                m_valid_reg <= res_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_reg.pose_valid;
    assign m_tdata  = {3'b0, out_reg.status, out_reg.frame_index, out_reg.playhead,
                       out_reg.playing, out_reg.pose};

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    typedef struct packed {
        logic [31:0] roll;
        logic [31:0] yaw;
        logic [31:0] pitch;
        logic [31:0] z;
        logic [31:0] y;
        logic [31:0] x;
    } pose_t;

    typedef struct {
        logic        pose_valid;
        pose_t       pose;
        logic        playing;
        logic [31:0] playhead;
        logic [9:0]  index;
        logic [1:0]  status;
    } pose_result_t;

    typedef struct {
        logic [2:0]  op;
        logic [31:0] tval;
        pose_t       pose;
        logic        has_fixed;
        logic [1:0]  fixed_status;
    } command_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [223:0] s_tdata = '0;
    logic [2:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [239:0] m_tdata;
    logic [0:0]   m_tuser;
    logic         cfg_wen = 1'b0;
    logic [15:0]  cfg_wdata = '0;

    keyframe_pose_playback dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
    );

    // predictor state
    logic [31:0] stamp_tab [kpp_pkg::MAX_FRAMES];
    pose_t       pose_tab [kpp_pkg::MAX_FRAMES];
    int unsigned n_frames;
    int unsigned cur_idx;
    logic [31:0] cur_time;
    logic        playing;
    logic [15:0] speed;

    pose_result_t expected_poses[$];
    int errors = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        #100000000;
        $display("** keyframe_pose_playback: FAILED **");
        $finish;
    end

    function automatic logic [31:0] lerp(logic [31:0] a, logic [31:0] b, logic [31:0] al);
        longint va, d, p, r;
        va = longint'($signed(a));
        d = longint'($signed(b)) - va;
        p = d * longint'(al);
        r = va + (p >>> 16);
        return r[31:0];
    endfunction

    function automatic pose_t blend(int unsigned i, logic [31:0] al);
        pose_t a, b, r;
        a = pose_tab[i];
        b = pose_tab[i + 1];
        r.x = lerp(a.x, b.x, al);
        r.y = lerp(a.y, b.y, al);
        r.z = lerp(a.z, b.z, al);
        r.pitch = lerp(a.pitch, b.pitch, al);
        r.yaw = lerp(a.yaw, b.yaw, al);
        r.roll = lerp(a.roll, b.roll, al);
        return r;
    endfunction

    function automatic pose_result_t playback_step(command_t c);
        pose_result_t r;
        int unsigned lo, hi, mid, i;
        logic [31:0] last_stamp, t, sa, sb, al;
        logic [63:0] adv, sum, num, q;
        r = '{default: '0};
        r.pose = '0;
        case (c.op)
            kpp_pkg::OP_APPEND: begin
                if (n_frames >= kpp_pkg::MAX_FRAMES) begin
                    r.status = kpp_pkg::ST_FULL;
                end else begin
                    stamp_tab[n_frames] = c.tval;
                    pose_tab[n_frames] = c.pose;
                    n_frames++;
                end
            end
            kpp_pkg::OP_CLEAR: begin
                n_frames = 0;
                cur_idx = 0;
                cur_time = 0;
                playing = 1'b0;
            end
            kpp_pkg::OP_STOP: playing = 1'b0;
            kpp_pkg::OP_START, kpp_pkg::OP_SEEK, kpp_pkg::OP_TICK: begin
                if (n_frames == 0) begin
                    r.status = kpp_pkg::ST_EMPTY;
                end else if (c.op == kpp_pkg::OP_START) begin
                    cur_time = 0;
                    cur_idx = 0;
                    playing = 1'b1;
                end else if (c.op == kpp_pkg::OP_SEEK) begin
                    last_stamp = stamp_tab[n_frames - 1];
                    cur_time = (c.tval < last_stamp) ? c.tval : last_stamp;
                    lo = 0;
                    hi = n_frames - 1;
                    while (lo < hi) begin
                        mid = (lo + hi) / 2;
                        if (stamp_tab[mid] < cur_time) lo = mid + 1;
                        else hi = mid;
                    end
                    cur_idx = lo;
                    r.pose_valid = 1'b1;
                    r.pose = pose_tab[lo];
                end else if (playing) begin
                    last_stamp = stamp_tab[n_frames - 1];
                    adv = (64'(c.tval) * 64'(speed)) >> 8;
                    sum = 64'(cur_time) + adv;
                    t = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
                    cur_time = t;
                    if (t >= last_stamp) begin
                        playing = 1'b0;
                        cur_time = last_stamp;
                    end else begin
                        i = cur_idx;
                        while (i + 1 < n_frames && stamp_tab[i + 1] <= t) i++;
                        cur_idx = i;
                        r.pose_valid = 1'b1;
                        if (i + 1 < n_frames) begin
                            sa = stamp_tab[i];
                            sb = stamp_tab[i + 1];
                            al = 0;
                            if (sb > sa && t > sa) begin
                                num = 64'(t - sa) << 16;
                                q = num / 64'(sb - sa);
                                al = (q > 65535) ? 32'd65535 : q[31:0];
                            end
                            r.pose = blend(i, al);
                        end else begin
                            r.pose = pose_tab[i];
                        end
                    end
                end
            end
            default: ;
        endcase
        r.playing = playing;
        r.playhead = cur_time;
        r.index = cur_idx[9:0];
        return r;
    endfunction

    task automatic send_command(command_t c);
        pose_result_t e;
        e = playback_step(c);
        if (c.has_fixed && e.status != c.fixed_status) begin
            $error("directed status: expected %0d, predicted %0d", c.fixed_status, e.status);
            errors++;
        end
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= c.op;
        s_tdata <= {c.pose, c.tval};
        expected_poses.push_back(e);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic drain();
        int guard;
        s_tvalid <= 1'b0;
        guard = 0;
        while (expected_poses.size() != 0 && guard < 200000) begin
            @(negedge aclk);
            guard++;
        end
        repeat (80) @(negedge aclk);
    endtask

    task automatic write_speed(logic [15:0] v);
        drain();
        cfg_wen <= 1'b1;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_wen <= 1'b0;
        speed = v;
    endtask

    function automatic pose_t random_pose();
        pose_t p;
        p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        return p;
    endfunction

    function automatic command_t make_cmd(logic [2:0] op, logic [31:0] tv);
        command_t c;
        c.op = op;
        c.tval = tv;
        c.pose = random_pose();
        c.has_fixed = 1'b0;
        c.fixed_status = kpp_pkg::ST_OK;
        return c;
    endfunction

    // receiver and checker
    always @(posedge aclk) begin
        pose_result_t e;
        pose_t got;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_poses.size() == 0) begin
                $error("result transfer with nothing expected");
                errors++;
            end else begin
                e = expected_poses.pop_front();
                got = m_tdata[191:0];
                if (m_tuser[0] !== e.pose_valid) begin
                    $error("pose_valid: expected %0d, actual %0d", e.pose_valid, m_tuser[0]);
                    errors++;
                end
                if (got.x !== e.pose.x) begin
                    $error("out_x: expected %h, actual %h", e.pose.x, got.x); errors++;
                end
                if (got.y !== e.pose.y) begin
                    $error("out_y: expected %h, actual %h", e.pose.y, got.y); errors++;
                end
                if (got.z !== e.pose.z) begin
                    $error("out_z: expected %h, actual %h", e.pose.z, got.z); errors++;
                end
                if (got.pitch !== e.pose.pitch) begin
                    $error("out_pitch: expected %h, actual %h", e.pose.pitch, got.pitch);
                    errors++;
                end
                if (got.yaw !== e.pose.yaw) begin
                    $error("out_yaw: expected %h, actual %h", e.pose.yaw, got.yaw); errors++;
                end
                if (got.roll !== e.pose.roll) begin
                    $error("out_roll: expected %h, actual %h", e.pose.roll, got.roll);
                    errors++;
                end
                if (m_tdata[192] !== e.playing) begin
                    $error("is_playing: expected %0d, actual %0d", e.playing, m_tdata[192]);
                    errors++;
                end
                if (m_tdata[224:193] !== e.playhead) begin
                    $error("playhead_time: expected %h, actual %h", e.playhead,
                           m_tdata[224:193]);
                    errors++;
                end
                if (m_tdata[234:225] !== e.index) begin
                    $error("frame_index: expected %0d, actual %0d", e.index, m_tdata[234:225]);
                    errors++;
                end
                if (m_tdata[236:235] !== e.status) begin
                    $error("status: expected %0d, actual %0d", e.status, m_tdata[236:235]);
                    errors++;
                end
            end
        end
    end

    always @(negedge aclk) begin
        m_tready <= (recv_stall_pct == 0) || ($urandom_range(99, 0) >= recv_stall_pct);
    end

    // one phase: a random mix of appends, ticks, seeks, starts, stops, clears and unused codes
    task automatic random_phase(int count);
        int k, sel;
        logic [31:0] stamp;
        command_t c;
        stamp = 0;
        k = 0;
        while (k < count) begin
            sel = $urandom_range(99, 0);
            if (n_frames < 2 || sel < 20) begin
                stamp = stamp + (($urandom_range(3, 0) == 0) ? 0 : $urandom_range(200000, 1));
                c = make_cmd(kpp_pkg::OP_APPEND,
                             ($urandom_range(30, 0) == 0) ? $urandom : stamp);
            end else if (sel < 60) begin
                c = make_cmd(kpp_pkg::OP_TICK, ($urandom_range(9, 0) == 0) ? $urandom :
                             $urandom_range(60000, 0));
                if (!playing && $urandom_range(2, 0) == 0) begin
                    c = make_cmd(kpp_pkg::OP_START, $urandom);
                end
            end else if (sel < 70) begin
                c = make_cmd(kpp_pkg::OP_SEEK, ($urandom_range(4, 0) == 0) ? $urandom :
                             $urandom_range(stamp + 10, 0));
            end else if (sel < 78) begin
                c = make_cmd(kpp_pkg::OP_START, $urandom);
            end else if (sel < 83) begin
                c = make_cmd(kpp_pkg::OP_STOP, $urandom);
            end else if (sel < 86) begin
                c = make_cmd(kpp_pkg::OP_CLEAR, $urandom);
                stamp = 0;
            end else if (sel < 89) begin
                c = make_cmd(3'($urandom_range(7, 6)), $urandom);
            end else begin
                c = make_cmd(kpp_pkg::OP_TICK, $urandom_range(30000, 0));
            end
            send_command(c);
            k++;
        end
    endtask

    initial begin
        command_t directed [$];
        command_t c;
        pose_t pmax, pmin;
        int k;
        pmax = {6{32'h7FFF_FFFF}};
        pmin = {6{32'h8000_0000}};
        n_frames = 0;
        cur_idx = 0;
        cur_time = 0;
        playing = 1'b0;
        speed = kpp_pkg::SPEED_RESET;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // empty table cases, then extremes, every op, unused codes
        directed.push_back('{kpp_pkg::OP_START, 32'h0, '0, 1'b1, kpp_pkg::ST_EMPTY});
        directed.push_back('{kpp_pkg::OP_SEEK, 32'hFFFF_FFFF, '0, 1'b1, kpp_pkg::ST_EMPTY});
        directed.push_back('{kpp_pkg::OP_TICK, 32'h1_0000, '0, 1'b1, kpp_pkg::ST_EMPTY});
        directed.push_back('{kpp_pkg::OP_APPEND, 32'h0, pmin, 1'b1, kpp_pkg::ST_OK});
        directed.push_back('{kpp_pkg::OP_APPEND, 32'h1_0000, pmax, 1'b1, kpp_pkg::ST_OK});
        directed.push_back('{kpp_pkg::OP_APPEND, 32'h1_0000, '0, 1'b1, kpp_pkg::ST_OK});
        directed.push_back('{kpp_pkg::OP_APPEND, 32'hFFFF_FFFF, pmin, 1'b1, kpp_pkg::ST_OK});
        directed.push_back('{kpp_pkg::OP_TICK, 32'h8000, '0, 1'b1, kpp_pkg::ST_OK});
        directed.push_back('{kpp_pkg::OP_START, 32'h0, '0, 1'b1, kpp_pkg::ST_OK});
        directed.push_back('{kpp_pkg::OP_TICK, 32'h8000, '0, 1'b1, kpp_pkg::ST_OK});
        directed.push_back('{kpp_pkg::OP_TICK, 32'h8000, '0, 1'b1, kpp_pkg::ST_OK});
        directed.push_back('{kpp_pkg::OP_TICK, 32'h0, '0, 1'b1, kpp_pkg::ST_OK});
        directed.push_back('{kpp_pkg::OP_SEEK, 32'h0, '0, 1'b1, kpp_pkg::ST_OK});
        directed.push_back('{kpp_pkg::OP_SEEK, 32'hFFFF_FFFF, '0, 1'b1, kpp_pkg::ST_OK});
        directed.push_back('{kpp_pkg::OP_SEEK, 32'h1_0000, '0, 1'b1, kpp_pkg::ST_OK});
        directed.push_back('{kpp_pkg::OP_STOP, 32'h0, '0, 1'b1, kpp_pkg::ST_OK});
        directed.push_back('{kpp_pkg::OP_START, 32'h0, '0, 1'b1, kpp_pkg::ST_OK});
        directed.push_back('{kpp_pkg::OP_TICK, 32'hFFFF_FFFF, '0, 1'b1, kpp_pkg::ST_OK});
        directed.push_back('{3'd6, 32'hFFFF_FFFF, pmax, 1'b1, kpp_pkg::ST_OK});
        directed.push_back('{3'd7, 32'h0, pmin, 1'b1, kpp_pkg::ST_OK});
        directed.push_back('{kpp_pkg::OP_CLEAR, 32'h0, '0, 1'b1, kpp_pkg::ST_OK});
        directed.push_back('{kpp_pkg::OP_SEEK, 32'h0, '0, 1'b1, kpp_pkg::ST_EMPTY});
        foreach (directed[i]) send_command(directed[i]);

        // fill the table to the top, then the full-table append
        for (k = 0; k < kpp_pkg::MAX_FRAMES; k++) begin
            send_command(make_cmd(kpp_pkg::OP_APPEND, 32'(k * 1000)));
        end
        c = make_cmd(kpp_pkg::OP_APPEND, 32'h0);
        c.has_fixed = 1'b1;
        c.fixed_status = kpp_pkg::ST_FULL;
        send_command(c);
        send_command(make_cmd(kpp_pkg::OP_SEEK, 32'd511_500));
        send_command(make_cmd(kpp_pkg::OP_START, 32'h0));
        send_command(make_cmd(kpp_pkg::OP_TICK, 32'd700));
        send_command(make_cmd(kpp_pkg::OP_TICK, 32'd2100));
        drain();
        send_command(make_cmd(kpp_pkg::OP_CLEAR, 32'h0));

        write_speed(16'hFFFF);
        random_phase(200);
        send_idle_pct = 85;
        write_speed(16'd0);
        random_phase(120);
        send_idle_pct = 0;
        recv_stall_pct = 85;
        write_speed(16'd1);
        random_phase(150);
        send_idle_pct = 13;
        recv_stall_pct = 13;
        write_speed(16'd128);
        random_phase(250);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_speed(16'($urandom_range(65535, 0)));
        random_phase(100);
        write_speed(kpp_pkg::SPEED_RESET);
        random_phase(100);

        drain();
        if (errors == 0 && expected_poses.size() == 0) begin
            $display("** keyframe_pose_playback: PASSED **");
        end else begin
            $display("** keyframe_pose_playback: FAILED **");
        end
        $finish;
    end
endmodule
